FILE: src/mdbcc_pkg.sv
// Shared types, command codes and response tables for the MDB coin changer responder.
// No dependencies; used by every module of the block except the checker.
package mdbcc_pkg;

  localparam logic [7:0] ADDR_TOP_BITS = 8'hF8;
  localparam logic [7:0] ADDR_MATCH    = 8'h08;
  localparam logic [7:0] CMD_RESET  = 8'h08;
  localparam logic [7:0] CMD_SETUP  = 8'h09;
  localparam logic [7:0] CMD_TUBE   = 8'h0A;
  localparam logic [7:0] CMD_POLL   = 8'h0B;
  localparam logic [7:0] CMD_MULTI0 = 8'h0C;
  localparam logic [7:0] CMD_MULTI1 = 8'h0D;
  localparam logic [7:0] ACK_BYTE   = 8'h00;

  localparam int unsigned IDX_W = 5;

  typedef enum logic [2:0] {
    RESP_NONE,
    RESP_ACK,
    RESP_SETUP,
    RESP_TUBE,
    RESP_DISPENSE
  } resp_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // front -> queue
  typedef struct packed {
    logic  push;
    resp_t code;
  } resp_req_t;

  // queue -> back
  typedef struct packed {
    logic  valid;
    resp_t code;
  } q_head_t;

  function automatic logic [IDX_W-1:0] table_len(input resp_t k);
    logic [IDX_W-1:0] n;
    case (k)
      RESP_SETUP:    n = IDX_W'(23);
      RESP_TUBE:     n = IDX_W'(18);
      RESP_DISPENSE: n = IDX_W'(3);
      default:       n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] setup_byte(input logic [IDX_W-1:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'h02;
      5'd1:    b = 8'h16;
      5'd2:    b = 8'h43;
      5'd3:    b = 8'h64;
      5'd4:    b = 8'h02;
      5'd5:    b = 8'h00;
      5'd6:    b = 8'hFF;
      5'd7:    b = 8'h01;
      5'd8:    b = 8'h02;
      5'd9:    b = 8'h05;
      5'd10:   b = 8'h0A;
      5'd11:   b = 8'h19;
      5'd12:   b = 8'h32;
      5'd13:   b = 8'h64;
      5'd14:   b = 8'hC8;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tube_byte(input logic [IDX_W-1:0] i);
    logic [7:0] b;
    case (i) inside
      [5'd2:5'd9]: b = 8'hFF;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] dispense_byte(input logic [IDX_W-1:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'h57;
      5'd1:    b = 8'hFF;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] table_byte(input resp_t k, input logic [IDX_W-1:0] i);
    logic [7:0] b;
    case (k)
      RESP_SETUP:    b = setup_byte(i);
      RESP_TUBE:     b = tube_byte(i);
      RESP_DISPENSE: b = dispense_byte(i);
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/mdbcc_front.sv
// Front end: frame tracking on received MDB bytes, classifies a closed frame
// into a response code. Depends on mdbcc_pkg.
module mdbcc_front
  import mdbcc_pkg::*;
#(
  parameter int unsigned FRAME_LIMIT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       rx_mode_bit,
  input  logic       event_idle,
  input  logic       q_full,
  output resp_req_t  req
);

  localparam int unsigned CNT_W = $clog2(FRAME_LIMIT);

  logic             dormant;
  logic [CNT_W-1:0] frame_count;
  logic [7:0]       running_sum;
  logic [7:0]       command_byte;

  logic  accept;
  resp_t resp;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    resp = RESP_NONE;
    if (frame_count == CNT_W'(1)) begin
      case (command_byte)
        CMD_RESET: resp = RESP_ACK;
        CMD_SETUP: resp = RESP_SETUP;
        CMD_TUBE:  resp = RESP_TUBE;
        CMD_POLL:  resp = event_idle ? RESP_ACK : RESP_DISPENSE;
        default:   resp = RESP_NONE;
      endcase
    end else begin
      case (command_byte) inside
        CMD_MULTI0, CMD_MULTI1: resp = RESP_ACK;
        default:                resp = RESP_NONE;
      endcase
    end
  end

  // a checksum match on a live frame within the length limit closes it and pushes its response code, if any
  always_comb begin
    req.push = accept && !dormant && (frame_count <= CNT_W'(FRAME_LIMIT - 2))
               && (running_sum == rx_byte) && (resp != RESP_NONE);
    req.code = resp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dormant     <= 1'b1;
      frame_count <= '0;
      running_sum <= '0;
    end else if (accept) begin
      if (dormant) begin
        if (rx_mode_bit) begin
          if ((rx_byte & ADDR_TOP_BITS) == ADDR_MATCH) begin
            frame_count <= CNT_W'(1);
            running_sum <= rx_byte;
            dormant     <= 1'b0;
          end else begin
            frame_count <= '0;
            running_sum <= '0;
          end
        end
      end else if (frame_count > CNT_W'(FRAME_LIMIT - 2)) begin
        // overflow drops the frame
        frame_count <= '0;
        running_sum <= '0;
        dormant     <= 1'b1;
      end else if (running_sum == rx_byte) begin
        frame_count <= '0;
        running_sum <= '0;
        dormant     <= 1'b1;
      end else begin
        running_sum <= running_sum + rx_byte;
        frame_count <= frame_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dormant && rx_mode_bit && ((rx_byte & ADDR_TOP_BITS) == ADDR_MATCH)) begin
      command_byte <= rx_byte;
    end
  end

endmodule

FILE: src/mdbcc_queue.sv
// Two-entry queue of response codes between front end and response sequencer.
// Depends on mdbcc_pkg.
module mdbcc_queue
  import mdbcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  resp_req_t req,
  output logic      q_full,
  output q_head_t   head,
  input  logic      pop
);

  resp_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign q_full     = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.code  = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_ptr] <= req.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({req.push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/mdbcc_back.sv
// Response sequencer: plays ACK or a ROM table plus checksum into the output
// register. Depends on mdbcc_pkg.
module mdbcc_back
  import mdbcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_head_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       tx_mode_bit,
  output logic       last_of_run
);

  seq_state_t       state;
  seq_state_t       state_next;
  resp_t            kind;
  logic [IDX_W-1:0] idx;
  logic [7:0]       sum;

  logic       advance;
  logic       at_end;
  logic       load;
  logic [7:0] byte_next;
  logic       mode_next;
  logic       last_next;
  logic [7:0] tab_b;

  assign advance = !out_valid || !out_stall;
  assign at_end  = (idx == table_len(kind));
  assign tab_b   = table_byte(kind, idx);

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (advance && head.valid && head.code != RESP_ACK) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (advance && at_end) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    byte_next = ACK_BYTE;
    mode_next = 1'b1;
    last_next = 1'b1;
    case (state)
      SEQ_IDLE: begin
        pop  = advance && head.valid;
        load = pop && head.code == RESP_ACK;
      end
      SEQ_RUN: begin
        load = advance;
        if (at_end) begin
          byte_next = sum;
        end else begin
          byte_next = tab_b;
          mode_next = 1'b0;
          last_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      tx_byte     <= byte_next;
      tx_mode_bit <= mode_next;
      last_of_run <= last_next;
    end
    if (state == SEQ_IDLE) begin
      kind <= head.code;
      idx  <= '0;
      sum  <= '0;
    end else if (advance && !at_end) begin
      idx <= idx + IDX_W'(1);
      sum <= sum + tab_b;
    end
  end

endmodule

FILE: src/mdb_coin_changer_responder.sv
// An ACK passes from the closing byte through the response queue to the output register; a
// table response also goes through the start state, then gives one byte a cycle (24 for SETUP)
// while out_stall is low. Input: one item per cycle while the 2-entry response queue has
// room; each table response spends its start state with no byte on the output.
// Reset (rst, synchronous): block dormant, queue empty, output empty.
module mdb_coin_changer_responder
  import mdbcc_pkg::*;
#(
  parameter int unsigned FRAME_LIMIT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       rx_mode_bit,
  input  logic       event_idle,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       tx_mode_bit,
  output logic       last_of_run
);

  resp_req_t req;
  q_head_t   head;
  logic      q_full;
  logic      pop;

  mdbcc_front #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .rx_mode_bit (rx_mode_bit),
    .event_idle  (event_idle),
    .q_full      (q_full),
    .req         (req)
  );

  mdbcc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  mdbcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tx_byte     (tx_byte),
    .tx_mode_bit (tx_mode_bit),
    .last_of_run (last_of_run)
  );

endmodule

FILE: src/mdbcc_checker.sv
// Port-level checks for the MDB coin changer responder, bound to the top level.
// Depends only on the top level's ports.
module mdbcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] tx_byte,
  input logic       tx_mode_bit,
  input logic       last_of_run
);

  // a held output item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(tx_mode_bit)
      && $stable(last_of_run))
    else $error("output item changed while stalled");

  // only ACK and checksum bytes carry the mode bit, and both end a response
  a_mode_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_mode_bit == last_of_run))
    else $error("mode bit and end of response disagree");

  a_rst_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_rst_in: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind mdb_coin_changer_responder mdbcc_checker u_mdbcc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .tx_byte     (tx_byte),
  .tx_mode_bit (tx_mode_bit),
  .last_of_run (last_of_run)
);
